// ===== sv/bmh_pkg.sv =====
// Shared constants and types for the binary max-heap unit.
package bmh_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;

    localparam logic signed [VAL_W-1:0] INT_MAX = {1'b0, {(VAL_W-1){1'b1}}};

    typedef enum logic [1:0] {
        KIND_INSERT  = 2'd0,
        KIND_EXTRACT = 2'd1,
        KIND_REMOVE  = 2'd2,
        KIND_CHANGE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

endpackage

// ===== sv/bmh_req_if.sv =====
// Request channel: operation kind, value and heap position.
interface bmh_req_if;
    logic                 valid;
    logic                 ready;
    bmh_pkg::t_kind       kind;
    logic signed [31:0]   value;
    logic        [3:0]    index;

    modport source (output valid, output kind, output value, output index, input ready);
    modport sink   (input valid, input kind, input value, input index, output ready);
endinterface

// ===== sv/bmh_rsp_if.sv =====
// Response channel: result value, status, count and current maximum.
interface bmh_rsp_if;
    logic                 valid;
    logic                 ready;
    logic signed [31:0]   result_value;
    bmh_pkg::t_status     status;
    logic        [4:0]    entry_count;
    logic signed [31:0]   top_value;
    logic                 heap_empty;

    modport source (output valid, output result_value, output status, output entry_count,
                    output top_value, output heap_empty, input ready);
    modport sink   (input valid, input result_value, input status, input entry_count,
                    input top_value, input heap_empty, output ready);
endinterface

// ===== sv/binary_max_heap_unit.sv =====
// Binary max-heap priority queue with a sequenced sift unit over a small memory.
//
//  channel | dir | handshake            | payload
//  i_req   | in  | valid / ready        | kind, value, index
//  o_rsp   | out | valid / ready        | result_value, status, entry_count, top_value,
//          |     |                      | heap_empty
//
// A request takes a read and a compare step per level compared, plus a step where a walk ends at the
// root or at an entry with no child, one to fetch the old entry on a change and one (two
// on a remove) to move the last entry to the root. Errors go straight to the response step.
// Reset clears the count; the heap memory is not cleared.
// A waiting response blocks only the final step of the next request.
module binary_max_heap_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bmh_req_if.sink    i_req,
    bmh_rsp_if.source  o_rsp
);

    localparam int IW = bmh_pkg::IDX_W;
    localparam int CW = bmh_pkg::CNT_W;
    localparam int XW = bmh_pkg::IDX_W + 2;
    localparam int VW = bmh_pkg::VAL_W;

    typedef enum logic [3:0] {
        S_IDLE, S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_CMP, S_OLD, S_TAKE, S_LAST, S_DONE
    } t_state;

    t_state                  r_state;
    logic [CW-1:0]           r_count;
    logic [IW-1:0]           r_pos;
    logic signed [VW-1:0]    r_val;
    logic                    r_take;
    logic signed [VW-1:0]    r_res;
    bmh_pkg::t_status        r_status;
    logic signed [VW-1:0]    r_top;
    logic signed [VW-1:0]    r_rda;
    logic signed [VW-1:0]    r_rdb;

    logic                    r_ov;
    logic signed [VW-1:0]    r_o_res;
    bmh_pkg::t_status        r_o_status;
    logic [CW-1:0]           r_o_count;
    logic signed [VW-1:0]    r_o_top;
    logic                    r_o_empty;

    logic signed [VW-1:0]    mem [bmh_pkg::CAPACITY];

    logic [IW-1:0]           parent;
    logic [XW-1:0]           lc_x;
    logic [XW-1:0]           rc_x;
    logic [XW-1:0]           cnt_x;
    logic [CW-1:0]           cnt_m1;
    logic                    lc_ok;
    logic                    rc_ok;
    logic                    up_go;
    logic                    take_l;
    logic                    take_r;
    logic                    dn_go;
    logic [IW-1:0]           child;
    logic signed [VW-1:0]    child_val;
    logic [IW-1:0]           rd_a;
    logic [IW-1:0]           rd_b;
    logic                    we;
    logic signed [VW-1:0]    wd;
    logic                    accept;
    logic                    out_free;
    logic                    idx_bad;
    t_state                  up_done;

    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_ov || o_rsp.ready;
    assign idx_bad  = CW'(i_req.index) >= r_count;
    assign up_done  = r_take ? S_TAKE : S_DONE;

    assign parent = IW'((r_pos - IW'(1)) >> 1);
    assign lc_x   = {1'b0, r_pos, 1'b1};
    assign rc_x   = lc_x + XW'(1);
    assign cnt_x  = XW'(r_count);
    assign cnt_m1 = r_count - CW'(1);
    assign lc_ok  = lc_x < cnt_x;
    assign rc_ok  = rc_x < cnt_x;

    assign up_go     = r_val > r_rda;
    assign take_l    = lc_ok && (r_rda > r_val);
    assign take_r    = rc_ok && (r_rdb > (take_l ? r_rda : r_val));
    assign dn_go     = take_l || take_r;
    assign child     = take_r ? rc_x[IW-1:0] : lc_x[IW-1:0];
    assign child_val = take_r ? r_rdb : r_rda;

    always_comb begin
        rd_a = '0;
        rd_b = rc_x[IW-1:0];
        unique case (r_state)
            S_IDLE:  rd_a = (i_req.kind == bmh_pkg::KIND_CHANGE) ? IW'(i_req.index)
                                                                 : cnt_m1[IW-1:0];
            S_UP_RD: rd_a = parent;
            S_DN_RD: rd_a = lc_x[IW-1:0];
            S_TAKE:  rd_a = cnt_m1[IW-1:0];
            default: rd_a = '0;
        endcase
    end

    // Hole-style sift: the moving value stays in r_val and lands once the walk stops.
    always_comb begin
        we = 1'b0;
        wd = r_val;
        unique case (r_state)
            S_UP_RD:  we = (r_pos == '0);
            S_UP_CMP: begin
                we = 1'b1;
                wd = up_go ? r_rda : r_val;
            end
            S_DN_RD:  we = !lc_ok;
            S_DN_CMP: begin
                we = 1'b1;
                wd = dn_go ? child_val : r_val;
            end
            default:  we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[r_pos] <= wd;
        end
        r_rda <= mem[rd_a];
        r_rdb <= mem[rd_b];
    end

    always_ff @(posedge i_clk) begin
        if (we && r_pos == '0) begin
            r_top <= wd;
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_status <= bmh_pkg::ST_OK;
                        r_res    <= '0;
                        r_take   <= 1'b0;
                        unique case (i_req.kind)
                            bmh_pkg::KIND_INSERT: begin
                                if (r_count >= CW'(bmh_pkg::CAPACITY)) begin
                                    r_status <= bmh_pkg::ST_FULL;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_pos   <= r_count[IW-1:0];
                                    r_val   <= i_req.value;
                                    r_count <= r_count + CW'(1);
                                    r_state <= S_UP_RD;
                                end
                            end
                            bmh_pkg::KIND_EXTRACT: begin
                                if (r_count == '0) begin
                                    r_status <= bmh_pkg::ST_EMPTY;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_res   <= r_top;
                                    r_state <= S_LAST;
                                end
                            end
                            bmh_pkg::KIND_REMOVE: begin
                                if (idx_bad) begin
                                    r_status <= bmh_pkg::ST_RANGE;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_pos   <= IW'(i_req.index);
                                    r_val   <= bmh_pkg::INT_MAX;
                                    r_take  <= 1'b1;
                                    r_state <= S_UP_RD;
                                end
                            end
                            bmh_pkg::KIND_CHANGE: begin
                                if (idx_bad) begin
                                    r_status <= bmh_pkg::ST_RANGE;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_pos   <= IW'(i_req.index);
                                    r_val   <= i_req.value;
                                    r_state <= S_OLD;
                                end
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_OLD: begin
                    r_state <= (r_val > r_rda) ? S_UP_RD : S_DN_RD;
                end
                S_UP_RD: begin
                    r_state <= (r_pos == '0) ? up_done : S_UP_CMP;
                end
                S_UP_CMP: begin
                    if (up_go) begin
                        r_pos   <= parent;
                        r_state <= S_UP_RD;
                    end else begin
                        r_state <= up_done;
                    end
                end
                S_TAKE: begin
                    r_state <= S_LAST;
                end
                S_LAST: begin
                    // move the last entry to the root and shrink
                    r_val   <= r_rda;
                    r_pos   <= '0;
                    r_count <= cnt_m1;
                    r_state <= S_DN_RD;
                end
                S_DN_RD: begin
                    r_state <= lc_ok ? S_DN_CMP : S_DONE;
                end
                S_DN_CMP: begin
                    if (dn_go) begin
                        r_pos   <= child;
                        r_state <= S_DN_RD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_o_res    <= r_res;
                        r_o_status <= r_status;
                        r_o_count  <= r_count;
                        r_o_top    <= (r_count != '0) ? r_top : '0;
                        r_o_empty  <= (r_count == '0);
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_ov;
    assign o_rsp.result_value = r_o_res;
    assign o_rsp.status       = r_o_status;
    assign o_rsp.entry_count  = 5'(r_o_count);
    assign o_rsp.top_value    = r_o_top;
    assign o_rsp.heap_empty   = r_o_empty;

endmodule

// ===== sv/bmh_checker.sv =====
// Port-level checks for the binary max-heap unit, bound to its top level.
module bmh_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_rsp_valid,
    input logic               i_rsp_ready,
    input logic signed [31:0] i_rsp_result_value,
    input logic [1:0]         i_rsp_status,
    input logic [4:0]         i_rsp_entry_count,
    input logic signed [31:0] i_rsp_top_value,
    input logic               i_rsp_heap_empty
);

    // hold a stalled response
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_entry_count)
            && $stable(i_rsp_top_value) && $stable(i_rsp_result_value))
        else $error("response changed while stalled");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_heap_empty == (i_rsp_entry_count == 5'd0)))
        else $error("empty flag disagrees with count");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_heap_empty |-> i_rsp_top_value == 32'sd0)
        else $error("nonzero top on empty heap");

    a_err_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status != bmh_pkg::ST_OK |-> i_rsp_result_value == 32'sd0)
        else $error("result value on failed request");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> 32'(i_rsp_entry_count) <= bmh_pkg::CAPACITY)
        else $error("count beyond capacity");

endmodule

bind binary_max_heap_unit bmh_checker u_bmh_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_rsp_valid        (o_rsp.valid),
    .i_rsp_ready        (o_rsp.ready),
    .i_rsp_result_value (o_rsp.result_value),
    .i_rsp_status       (o_rsp.status),
    .i_rsp_entry_count  (o_rsp.entry_count),
    .i_rsp_top_value    (o_rsp.top_value),
    .i_rsp_heap_empty   (o_rsp.heap_empty)
);

// ===== test/tb_top.sv =====
// Self-checking testbench for the binary max-heap unit with a heap scoreboard.
`timescale 1ns / 100ps

module tb_top;

    localparam int          LONG_HOLD   = 400;
    localparam int          DRAIN_WAIT  = 40;
    localparam int          PHASES      = 13;
    localparam int          PHASE_ITEMS = 56;
    localparam longint      RUN_LIMIT   = 3_000_000;
    localparam logic signed [31:0] INT_MIN = {1'b1, 31'b0};

    typedef enum int { MIX_GROW, MIX_SHRINK, MIX_EVEN } t_mix;
    typedef enum int { IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY } t_idle;

    typedef struct {
        logic signed [31:0] result_value;
        bmh_pkg::t_status   status;
        logic [4:0]         entry_count;
        logic signed [31:0] top_value;
        logic               heap_empty;
    } t_heap_rsp;

    // Heap image kept in step with accepted requests; responses are checked in order.
    class t_heap_scoreboard;
        logic signed [31:0] slots [bmh_pkg::CAPACITY];
        int unsigned        fill;
        t_heap_rsp          awaited [$];
        int unsigned        errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function void swap_slots(int unsigned a, int unsigned b);
            logic signed [31:0] t;
            t        = slots[a];
            slots[a] = slots[b];
            slots[b] = t;
        endfunction

        function void float_up(int unsigned pos);
            int unsigned parent;
            while (pos > 0) begin
                parent = (pos - 1) / 2;
                if (!(slots[pos] > slots[parent]))
                    break;
                swap_slots(pos, parent);
                pos = parent;
            end
        endfunction

        function void sink_down(int unsigned pos);
            int unsigned best, lc, rc;
            forever begin
                best = pos;
                lc   = 2 * pos + 1;
                rc   = 2 * pos + 2;
                if (lc < fill && slots[lc] > slots[best])
                    best = lc;
                if (rc < fill && slots[rc] > slots[best])
                    best = rc;
                if (best == pos)
                    break;
                swap_slots(pos, best);
                pos = best;
            end
        endfunction

        function logic signed [31:0] pop_root();
            logic signed [31:0] top;
            top      = slots[0];
            slots[0] = slots[fill - 1];
            fill--;
            sink_down(0);
            return top;
        endfunction

        function void note_request(bmh_pkg::t_kind k, logic signed [31:0] v, logic [3:0] idx);
            t_heap_rsp          r;
            logic signed [31:0] prior;
            r.result_value = '0;
            r.status       = bmh_pkg::ST_OK;
            case (k)
                bmh_pkg::KIND_INSERT: begin
                    if (fill >= bmh_pkg::CAPACITY) begin
                        r.status = bmh_pkg::ST_FULL;
                    end else begin
                        slots[fill] = v;
                        fill++;
                        float_up(fill - 1);
                    end
                end
                bmh_pkg::KIND_EXTRACT: begin
                    if (fill == 0)
                        r.status = bmh_pkg::ST_EMPTY;
                    else
                        r.result_value = pop_root();
                end
                default: begin
                    if (idx >= fill) begin
                        r.status = bmh_pkg::ST_RANGE;
                    end else if (k == bmh_pkg::KIND_REMOVE) begin
                        // raise to the top, then take the root away
                        slots[idx] = bmh_pkg::INT_MAX;
                        float_up(idx);
                        void'(pop_root());
                    end else begin
                        prior      = slots[idx];
                        slots[idx] = v;
                        if (v > prior)
                            float_up(idx);
                        else
                            sink_down(idx);
                    end
                end
            endcase
            r.entry_count = 5'(fill);
            r.top_value   = (fill != 0) ? slots[0] : '0;
            r.heap_empty  = (fill == 0);
            awaited.push_back(r);
        endfunction

        function void report_field(string field, logic signed [31:0] want,
                                   logic signed [31:0] got);
            $display("%0t ns: heap response %s wrong, expected %0d, actual %0d",
                     $time, field, want, got);
            errors++;
        endfunction

        function void check_response(t_heap_rsp got);
            t_heap_rsp want;
            if (awaited.size() == 0) begin
                $display({"%0t ns: heap response with none outstanding, expected none, ",
                          "actual %0d/%0d/%0d/%0d/%0d"},
                         $time, got.result_value, got.status, got.entry_count,
                         got.top_value, got.heap_empty);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.result_value !== want.result_value)
                report_field("result_value", want.result_value, got.result_value);
            if (got.status !== want.status)
                report_field("status", want.status, got.status);
            if (got.entry_count !== want.entry_count)
                report_field("entry_count", want.entry_count, got.entry_count);
            if (got.top_value !== want.top_value)
                report_field("top_value", want.top_value, got.top_value);
            if (got.heap_empty !== want.heap_empty)
                report_field("heap_empty", want.heap_empty, got.heap_empty);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    bmh_req_if req_bus ();
    bmh_rsp_if rsp_bus ();

    binary_max_heap_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    t_heap_scoreboard sb;
    t_idle            req_idle      = IDLE_NONE;
    t_idle            rsp_idle      = IDLE_NONE;
    bit               long_hold_req = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #(RUN_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int unsigned idle_burst(t_idle m);
        case (m)
            IDLE_LIGHT: return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 14) : 0;
            IDLE_HEAVY: return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 14) : 0;
            default:    return 0;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(0, 15);
        if (roll < 2) begin
            case ($urandom_range(0, 4))
                0:       return INT_MIN;
                1:       return bmh_pkg::INT_MAX;
                2:       return -1;
                3:       return 1;
                default: return 0;
            endcase
        end
        // narrow range to get equal priorities
        if (roll < 6)
            return $signed($urandom_range(0, 16)) - 8;
        return $urandom;
    endfunction

    function automatic logic [3:0] pick_index();
        if (sb.fill != 0 && $urandom_range(0, 7) != 0)
            return 4'($urandom_range(0, sb.fill - 1));
        return 4'($urandom_range(0, 15));
    endfunction

    function automatic bmh_pkg::t_kind pick_kind(t_mix mix);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_GROW: begin
                if (roll < 55) return bmh_pkg::KIND_INSERT;
                if (roll < 70) return bmh_pkg::KIND_EXTRACT;
                if (roll < 85) return bmh_pkg::KIND_REMOVE;
                return bmh_pkg::KIND_CHANGE;
            end
            MIX_SHRINK: begin
                if (roll < 20) return bmh_pkg::KIND_INSERT;
                if (roll < 55) return bmh_pkg::KIND_EXTRACT;
                if (roll < 80) return bmh_pkg::KIND_REMOVE;
                return bmh_pkg::KIND_CHANGE;
            end
            default: begin
                if (roll < 35) return bmh_pkg::KIND_INSERT;
                if (roll < 60) return bmh_pkg::KIND_EXTRACT;
                if (roll < 80) return bmh_pkg::KIND_REMOVE;
                return bmh_pkg::KIND_CHANGE;
            end
        endcase
    endfunction

    // Offer one request from a falling edge and hold it until accepted.
    task automatic send_request(bmh_pkg::t_kind k, logic signed [31:0] v, logic [3:0] idx);
        int unsigned gap;
        gap = idle_burst(req_idle);
        if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.kind  <= k;
        req_bus.value <= v;
        req_bus.index <= idx;
        @(posedge i_clk);
        while (!req_bus.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : bus_monitor
        t_heap_rsp seen;
        if (i_rst_n) begin
            if (req_bus.valid && req_bus.ready)
                sb.note_request(req_bus.kind, req_bus.value, req_bus.index);
            if (rsp_bus.valid && rsp_bus.ready) begin
                seen.result_value = rsp_bus.result_value;
                seen.status       = rsp_bus.status;
                seen.entry_count  = rsp_bus.entry_count;
                seen.top_value    = rsp_bus.top_value;
                seen.heap_empty   = rsp_bus.heap_empty;
                sb.check_response(seen);
            end
        end
    end

    initial begin : rsp_ready_ctrl
        int unsigned hold_left;
        hold_left     = 0;
        rsp_bus.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end else if (hold_left == 0) begin
                hold_left = idle_burst(rsp_idle);
            end
            if (hold_left != 0) begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int unsigned ph, n;
        t_mix        mix;
        sb            = new();
        i_rst_n       = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.kind  = bmh_pkg::KIND_INSERT;
        req_bus.value = '0;
        req_bus.index = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        req_idle = IDLE_LIGHT;
        rsp_idle = IDLE_LIGHT;

        // errors on an empty heap
        send_request(bmh_pkg::KIND_EXTRACT, 0, 4'd0);
        send_request(bmh_pkg::KIND_REMOVE, 0, 4'd0);
        send_request(bmh_pkg::KIND_CHANGE, bmh_pkg::INT_MAX, 4'd15);
        // extremes, then fill to capacity
        send_request(bmh_pkg::KIND_INSERT, INT_MIN, 4'd0);
        send_request(bmh_pkg::KIND_INSERT, bmh_pkg::INT_MAX, 4'd0);
        send_request(bmh_pkg::KIND_INSERT, 0, 4'd0);
        for (n = 0; n < bmh_pkg::CAPACITY - 3; n++)
            send_request(bmh_pkg::KIND_INSERT, $signed(32'(n) * 32'h1357_9BDF), 4'(n));
        send_request(bmh_pkg::KIND_INSERT, -1, 4'd0);
        // raise, lower, keep equal
        send_request(bmh_pkg::KIND_CHANGE, bmh_pkg::INT_MAX, 4'd15);
        send_request(bmh_pkg::KIND_CHANGE, INT_MIN, 4'd0);
        send_request(bmh_pkg::KIND_CHANGE, sb.slots[7], 4'd7);
        send_request(bmh_pkg::KIND_REMOVE, 0, 4'd15);
        send_request(bmh_pkg::KIND_REMOVE, 0, 4'd0);
        send_request(bmh_pkg::KIND_CHANGE, 5, 4'd14);
        send_request(bmh_pkg::KIND_EXTRACT, 0, 4'd0);

        for (ph = 0; ph < PHASES; ph++) begin
            mix      = (ph % 4 == 3) ? MIX_EVEN : ((ph % 2 == 0) ? MIX_GROW : MIX_SHRINK);
            req_idle = t_idle'($urandom_range(0, 2));
            rsp_idle = t_idle'($urandom_range(0, 2));
            if (ph == 2) begin
                // stall the response side while requests keep coming
                req_idle      = IDLE_NONE;
                long_hold_req = 1'b1;
            end
            if (ph == PHASES - 1) begin
                req_idle = IDLE_NONE;
                rsp_idle = IDLE_NONE;
            end
            for (n = 0; n < PHASE_ITEMS; n++)
                send_request(pick_kind(mix), pick_value(), pick_index());
        end
        req_bus.valid <= 1'b0;

        while (sb.awaited.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/bmh_pkg.sv
sv/bmh_req_if.sv
sv/bmh_rsp_if.sv
sv/binary_max_heap_unit.sv
sv/bmh_checker.sv
test/tb_top.sv
